### design/swk_pkg.sv
// Shared constants and control types for the sliding-window rank-order filter.
// No dependencies; compile before the interfaces and modules.
package swk_pkg;

  localparam int SWK_WINDOW_MAX   = 64;
  localparam int SWK_SAMPLE_WIDTH = 32;
  localparam int SWK_LEN_W        = 7;
  localparam int SWK_RANK_W       = 7;

  // Per-item controls broadcast from the top level to every cell
  typedef struct packed {
    logic step;     // item accepted: load the new cell contents
    logic del_en;   // window full after insertion: remove the oldest sample
    logic new_gex;  // incoming sample is >= the sample being removed
  } swk_ctl_t;

  // Comparison flags handed from each cell to its upper neighbour
  typedef struct packed {
    logic ge;       // slot at or above the insertion point
    logic gex;      // slot holds a sample >= the sample being removed
  } swk_flags_t;

endpackage

### design/swk_ifs.sv
// Valid/ready channel interfaces of the rank-order filter: sample input,
// result output and window-length configuration. Uses swk_pkg for widths.
interface swk_in_if import swk_pkg::*; #(
  parameter int SAMPLE_WIDTH = SWK_SAMPLE_WIDTH
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_value;
  logic [SWK_RANK_W-1:0]          rank;

  modport source (output valid, output sample_value, output rank, input ready);
  modport sink   (input valid, input sample_value, input rank, output ready);
endinterface

interface swk_out_if import swk_pkg::*; #(
  parameter int SAMPLE_WIDTH = SWK_SAMPLE_WIDTH
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] kth_value;

  modport source (output valid, output kth_value, input ready);
  modport sink   (input valid, input kth_value, output ready);
endinterface

interface swk_cfg_if import swk_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [SWK_LEN_W-1:0] window_length;

  modport source (output valid, output window_length, input ready);
  modport sink   (input valid, input window_length, output ready);
endinterface

### design/swk_cell.sv
// One slot of the sorted window: holds a sample and its age, and computes
// its next contents from itself and its two neighbours. Uses swk_pkg.
module swk_cell import swk_pkg::*; #(
  parameter int IDX   = 0,
  parameter int SW    = SWK_SAMPLE_WIDTH,
  parameter int AGE_W = 6,
  parameter int CNT_W = 7
) (
  input  logic                 clk,
  input  swk_ctl_t             ctl,
  input  logic [CNT_W-1:0]     fill,
  input  logic signed [SW-1:0] new_val,
  input  logic signed [SW-1:0] oldest_val,
  input  logic [AGE_W-1:0]     tgt_age,
  input  logic [AGE_W-1:0]     sel_idx,
  input  logic signed [SW-1:0] prev_val,
  input  logic [AGE_W-1:0]     prev_age,
  input  swk_flags_t           prev_flags,
  input  logic signed [SW-1:0] next_m_val,
  input  logic [AGE_W-1:0]     next_m_age,
  output logic signed [SW-1:0] cur_val,
  output logic [AGE_W-1:0]     cur_age,
  output swk_flags_t           cur_flags,
  output logic signed [SW-1:0] m_val,
  output logic [AGE_W-1:0]     m_age,
  output logic                 match,
  output logic signed [SW-1:0] match_val,
  output logic signed [SW-1:0] sel_val
);

  logic signed [SW-1:0] val_r, val_nxt;
  logic [AGE_W-1:0]     age_r, age_nxt;
  logic                 valid;
  logic                 m_gex;

  assign valid = (IDX < int'(fill));

  assign cur_flags.ge  = !valid || (val_r > new_val);
  assign cur_flags.gex = valid && (val_r >= oldest_val);
  assign cur_val       = val_r;
  assign cur_age       = age_r;

  // merged list: old contents with the new sample slotted in
  always_comb begin
    if (!cur_flags.ge) begin
      m_val = val_r;
      m_age = AGE_W'(age_r + 1'b1);
      m_gex = cur_flags.gex;
    end else if (prev_flags.ge) begin
      m_val = prev_val;
      m_age = AGE_W'(prev_age + 1'b1);
      m_gex = prev_flags.gex;
    end else begin
      m_val = new_val;
      m_age = '0;
      m_gex = ctl.new_gex;
    end
  end

  // close the gap left by the removed sample
  always_comb begin
    if (ctl.del_en && m_gex) begin
      val_nxt = next_m_val;
      age_nxt = next_m_age;
    end else begin
      val_nxt = m_val;
      age_nxt = m_age;
    end
  end

  assign match     = valid && (age_r == tgt_age);
  assign match_val = match ? val_r : '0;
  assign sel_val   = (sel_idx == AGE_W'(IDX)) ? m_val : '0;

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      val_r <= val_nxt;
      age_r <= age_nxt;
    end
  end

endmodule

### design/swk_obuf.sv
// Two-entry result buffer in front of the output channel, so an item can
// be taken while a result waits. Uses swk_pkg and swk_out_if.
module swk_obuf import swk_pkg::*; #(
  parameter int SW = SWK_SAMPLE_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic signed [SW-1:0] push_data,
  output logic                 room,
  swk_out_if.source            out_ch
);

  logic [1:0]           cnt_r, cnt_nxt;
  logic signed [SW-1:0] d0_r, d0_nxt;
  logic signed [SW-1:0] d1_r, d1_nxt;
  logic                 pop;

  assign pop              = out_ch.valid && out_ch.ready;
  assign out_ch.valid     = (cnt_r != 2'd0);
  assign out_ch.kth_value = d0_r;
  assign room             = (cnt_r != 2'd2);

  always_comb begin
    cnt_nxt = cnt_r;
    d0_nxt  = d0_r;
    d1_nxt  = d1_r;
    case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) begin
          d0_nxt = push_data;
        end else begin
          d1_nxt = push_data;
        end
        cnt_nxt = cnt_r + 2'd1;
      end
      2'b01: begin
        d0_nxt  = d1_r;
        cnt_nxt = cnt_r - 2'd1;
      end
      2'b11: begin
        if (cnt_r == 2'd1) begin
          d0_nxt = push_data;
        end else begin
          d0_nxt = d1_r;
          d1_nxt = push_data;
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d0_r <= d0_nxt;
    d1_r <= d1_nxt;
  end

endmodule

### design/sliding_window_kth_smallest.sv
// Top level of the sliding-window rank-order filter: a row of sorted cells
// plus a two-entry result buffer. Uses swk_pkg, swk_ifs, swk_cell, swk_obuf.
//
// Usage:
//   in_ch  : samples with a rank, valid/ready; taken when both are high.
//   out_ch : rank-th smallest sample of the full window, valid/ready.
//   cfg_ch : window length write, always ready; write only while idle.
//            A write empties the window.
// For each item the cells compare the new sample in parallel, shift to make
// room, pick the ranked slot and close the gap left by the oldest sample in
// the same clock. One item per cycle is sustained while the result buffer
// has room. Items arriving before the window is full give no result. A
// result is buffered and leaves on out_ch after those ahead of it.
// Reset empties the window and sets the window length to one.
// When out_ch stalls, two results are held; in_ch then drops ready until
// the receiver takes one.
module sliding_window_kth_smallest import swk_pkg::*; #(
  parameter int WINDOW_MAX   = SWK_WINDOW_MAX,
  parameter int SAMPLE_WIDTH = SWK_SAMPLE_WIDTH
) (
  input logic        clk,
  input logic        rst_n,
  swk_in_if.sink     in_ch,
  swk_out_if.source  out_ch,
  swk_cfg_if.sink    cfg_ch
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int N     = WINDOW_MAX;
  localparam int CNT_W = $clog2(N + 1);
  localparam int AGE_W = (N > 1) ? $clog2(N) : 1;

  logic [SWK_LEN_W-1:0] len_r;
  logic [CNT_W-1:0]     fill_r, fill_nxt;
  logic [CNT_W-1:0]     eff_len;
  logic [CNT_W-1:0]     rank_eff;
  logic [AGE_W-1:0]     sel_idx;
  logic [AGE_W-1:0]     tgt_age;
  logic                 accept;
  logic                 full_after;
  logic                 room;
  logic                 push;
  logic                 cfg_wr;
  logic signed [SW-1:0] new_val;
  logic signed [SW-1:0] oldest_or;
  logic signed [SW-1:0] oldest_val;
  logic signed [SW-1:0] sel_or;
  swk_ctl_t             ctl;

  logic signed [SW-1:0] cur_val   [N];
  logic [AGE_W-1:0]     cur_age   [N];
  swk_flags_t           cur_flags [N];
  logic signed [SW-1:0] m_val     [N];
  logic [AGE_W-1:0]     m_age     [N];
  logic signed [SW-1:0] match_val [N];
  logic signed [SW-1:0] sel_val   [N];
  logic [N-1:0]         match_vec;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;
  assign in_ch.ready  = room;
  assign accept       = in_ch.valid && in_ch.ready;
  assign new_val      = in_ch.sample_value;

  // clamp the window length to 1..WINDOW_MAX
  always_comb begin
    if (len_r == '0) begin
      eff_len = CNT_W'(1);
    end else if (int'(len_r) > N) begin
      eff_len = CNT_W'(N);
    end else begin
      eff_len = CNT_W'(len_r);
    end
  end

  // clamp the rank to 1..window length
  always_comb begin
    if (in_ch.rank == '0) begin
      rank_eff = CNT_W'(1);
    end else if (int'(in_ch.rank) > int'(eff_len)) begin
      rank_eff = eff_len;
    end else begin
      rank_eff = CNT_W'(in_ch.rank);
    end
  end

  assign sel_idx    = AGE_W'(rank_eff - CNT_W'(1));
  assign tgt_age    = AGE_W'(eff_len - CNT_W'(2));
  assign full_after = (CNT_W'(fill_r + CNT_W'(1)) == eff_len);
  assign fill_nxt   = full_after ? fill_r : CNT_W'(fill_r + CNT_W'(1));

  always_comb begin
    oldest_or = '0;
    sel_or    = '0;
    for (int i = 0; i < N; i++) begin
      oldest_or = oldest_or | match_val[i];
      sel_or    = sel_or | sel_val[i];
    end
  end

  // with a one-sample window the new sample is itself the oldest
  assign oldest_val  = (eff_len == CNT_W'(1)) ? new_val : oldest_or;
  assign ctl.step    = accept;
  assign ctl.del_en  = accept && full_after;
  assign ctl.new_gex = (new_val >= oldest_val);
  assign push        = accept && full_after;

  for (genvar g = 0; g < N; g++) begin : g_cell
    logic signed [SW-1:0] prev_val;
    logic [AGE_W-1:0]     prev_age;
    swk_flags_t           prev_flags;
    logic signed [SW-1:0] next_m_val;
    logic [AGE_W-1:0]     next_m_age;

    if (g == 0) begin : g_first
      assign prev_val   = '0;
      assign prev_age   = '0;
      assign prev_flags = '0;
    end else begin : g_mid
      assign prev_val   = cur_val[g-1];
      assign prev_age   = cur_age[g-1];
      assign prev_flags = cur_flags[g-1];
    end

    if (g == N - 1) begin : g_last
      assign next_m_val = '0;
      assign next_m_age = '0;
    end else begin : g_inner
      assign next_m_val = m_val[g+1];
      assign next_m_age = m_age[g+1];
    end

    swk_cell #(
      .IDX   (g),
      .SW    (SW),
      .AGE_W (AGE_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .fill       (fill_r),
      .new_val    (new_val),
      .oldest_val (oldest_val),
      .tgt_age    (tgt_age),
      .sel_idx    (sel_idx),
      .prev_val   (prev_val),
      .prev_age   (prev_age),
      .prev_flags (prev_flags),
      .next_m_val (next_m_val),
      .next_m_age (next_m_age),
      .cur_val    (cur_val[g]),
      .cur_age    (cur_age[g]),
      .cur_flags  (cur_flags[g]),
      .m_val      (m_val[g]),
      .m_age      (m_age[g]),
      .match      (match_vec[g]),
      .match_val  (match_val[g]),
      .sel_val    (sel_val[g])
    );
  end

  swk_obuf #(
    .SW (SW)
  ) u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (sel_or),
    .room      (room),
    .out_ch    (out_ch)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= SWK_LEN_W'(1);
      fill_r <= '0;
    end else if (cfg_wr) begin
      len_r  <= cfg_ch.window_length;
      fill_r <= '0;
    end else if (accept) begin
      fill_r <= fill_nxt;
    end
  end

  a_fill_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < eff_len)
    else $error("window fill count reached the window length");

  a_one_oldest: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.del_en && (eff_len != CNT_W'(1))) |-> $onehot(match_vec))
    else $error("removal without exactly one oldest sample");

  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ch.ready) |-> $past(push))
    else $error("input ready dropped without a result being buffered");

endmodule

### bench/tb.sv
// Self-checking bench for sliding_window_kth_smallest: random bursts of samples
// against an in-bench rank-order predictor, with window-length changes between
// phases. Depends on swk_pkg and the channel interfaces in swk_ifs.
module tb;
  import swk_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [SWK_SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [SWK_RANK_W-1:0]              rank_t;
  typedef logic [SWK_LEN_W-1:0]               len_t;

  localparam sample_t SAMPLE_MIN = {1'b1, {(SWK_SAMPLE_WIDTH-1){1'b0}}};
  localparam sample_t SAMPLE_MAX = {1'b0, {(SWK_SAMPLE_WIDTH-1){1'b1}}};

  // Predicts the rank-th smallest sample of each full window and keeps the
  // results still owed by the block.
  class kth_scoreboard;
    int unsigned window_len;
    sample_t     window_q[$];
    sample_t     kth_expected_q[$];
    int          errors;

    function new();
      window_len = 1;
      errors     = 0;
    endfunction

    // A length write empties the window
    function void write_length(len_t len);
      window_len = len;
      window_q.delete();
    endfunction

    function void note_sample(sample_t value, rank_t rank);
      int unsigned full_len;
      int unsigned pick;
      int unsigned below;
      int unsigned at_or_below;
      full_len = window_len;
      if (full_len < 1) full_len = 1;
      if (full_len > SWK_WINDOW_MAX) full_len = SWK_WINDOW_MAX;
      window_q.push_back(value);
      if (window_q.size() < full_len) return;
      pick = rank;
      if (pick < 1) pick = 1;
      if (pick > full_len) pick = full_len;
      // x is the pick-th smallest when fewer than pick lie below it and at
      // least pick lie at or below it
      foreach (window_q[i]) begin
        below       = 0;
        at_or_below = 0;
        foreach (window_q[j]) begin
          if (window_q[j] < window_q[i]) below++;
          if (window_q[j] <= window_q[i]) at_or_below++;
        end
        if (below < pick && pick <= at_or_below) begin
          kth_expected_q.push_back(window_q[i]);
          break;
        end
      end
      // drop the oldest sample
      void'(window_q.pop_front());
    endfunction

    function void check_result(sample_t got);
      sample_t want;
      if (kth_expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected kth_value %0d", got);
        return;
      end
      want = kth_expected_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("kth_value mismatch: expected %0d, got %0d", want, got);
      end
    endfunction

    function int pending();
      return kth_expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic hold_request;
  int   burst_left;

  swk_in_if  in_ch();
  swk_out_if out_ch();
  swk_cfg_if cfg_ch();

  kth_scoreboard board = new();

  sliding_window_kth_smallest u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Results are checked before the same edge's input is noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) board.check_result(out_ch.kth_value);
      if (in_ch.valid && in_ch.ready) board.note_sample(in_ch.sample_value, in_ch.rank);
      if (cfg_ch.valid && cfg_ch.ready) board.write_length(cfg_ch.window_length);
    end
  end

  // Receiver: segments of always-ready, coin-flip and mostly-stalled, plus
  // one long hold-off once the pressure phase asks for it
  initial begin
    int seg_left;
    int seg_mode;
    int hold_left;
    bit hold_done;
    seg_left  = 0;
    seg_mode  = 0;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 300;
        out_ch.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_mode = $urandom_range(0, 2);
          seg_left = $urandom_range(1, 40);
        end else begin
          seg_left--;
        end
        case (seg_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 1) == 1);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Hold valid and the item until the block takes it; leave valid high
  task automatic send_item(input sample_t value, input rank_t rank);
    in_ch.valid        <= 1'b1;
    in_ch.sample_value <= value;
    in_ch.rank         <= rank;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drain every owed result, let the block settle, then write the length
  task automatic write_length(input len_t len);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.window_length <= len;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic sample_t pick_sample();
    int near_zero;
    case ($urandom_range(0, 9))
      0: return SAMPLE_MIN;
      1: return SAMPLE_MAX;
      2, 3, 4: begin
        // narrow range: plenty of equal samples
        near_zero = $urandom_range(0, 8);
        return sample_t'(near_zero - 4);
      end
      default: return sample_t'($urandom());
    endcase
  endfunction

  task automatic run_phase(input len_t len, input int count, input bit pressure);
    int unsigned full_len;
    rank_t       rank;
    full_len = len;
    if (full_len < 1) full_len = 1;
    if (full_len > SWK_WINDOW_MAX) full_len = SWK_WINDOW_MAX;
    write_length(len);
    if (pressure) hold_request <= 1'b1;
    repeat (count) begin
      case ($urandom_range(0, 7))
        0: rank = '0;
        1: rank = rank_t'($urandom_range(0, 127));
        default: rank = rank_t'($urandom_range(1, full_len));
      endcase
      send_item(pick_sample(), rank);
      burst_left--;
      if (burst_left <= 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = $urandom_range(1, 30);
      end
    end
  endtask

  initial begin
    rst_n                <= 1'b0;
    hold_request         <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.sample_value   <= '0;
    in_ch.rank           <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.window_length <= '0;
    burst_left = 10;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset length of one: every item gives itself back, rank clamped
    send_item(SAMPLE_MIN, rank_t'(0));
    send_item(SAMPLE_MAX, rank_t'(127));
    send_item(sample_t'(0), rank_t'(1));

    // Short window with duplicates: removal takes exactly one copy
    write_length(len_t'(4));
    send_item(sample_t'(7), rank_t'(1));
    send_item(sample_t'(7), rank_t'(2));
    send_item(sample_t'(-3), rank_t'(0));
    send_item(sample_t'(7), rank_t'(4));
    send_item(sample_t'(7), rank_t'(3));
    send_item(sample_t'(-3), rank_t'(127));
    send_item(SAMPLE_MIN, rank_t'(1));
    send_item(SAMPLE_MAX, rank_t'(64));
    send_item(sample_t'(7), rank_t'(2));
    send_item(sample_t'(-1), rank_t'(5));
    send_item(sample_t'(-1), rank_t'(1));

    // Random phases over several lengths, including zero and above the maximum
    run_phase(len_t'(2), 80, 1'b1);
    run_phase(len_t'(1), 30, 1'b0);
    run_phase(len_t'(64), 90, 1'b0);
    run_phase(len_t'(127), 80, 1'b0);
    run_phase(len_t'(65), 75, 1'b0);
    run_phase(len_t'(3), 40, 1'b0);
    run_phase(len_t'(0), 20, 1'b0);
    run_phase(len_t'(16), 50, 1'b0);
    run_phase(len_t'($urandom_range(1, 12)), 40, 1'b0);
    run_phase(len_t'($urandom_range(0, 127)), 80, 1'b0);
    run_phase(len_t'(8), 40, 1'b0);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
